// ===== design/rational_accumulator_alu_macros.svh =====
// Assertion macros shared by the rational accumulator ALU modules.
// Depends on nothing; every user must have aclk and aresetn in scope.
`ifndef RATIONAL_ACCUMULATOR_ALU_MACROS_SVH
`define RATIONAL_ACCUMULATOR_ALU_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RAA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RAA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/raa_pkg.sv =====
// Shared types and codes for the rational accumulator ALU.
// No dependencies; used by raa_muldiv and rational_accumulator_alu.
`timescale 1ns / 1ps

package raa_pkg;

    localparam int FIELD_BITS = 32;
    localparam int DEN_OUT_BITS = 31;
    localparam int OP_BITS = 3;
    localparam int CMP_BITS = 2;
    localparam int S_TDATA_BITS = 72;
    localparam int M_TDATA_BITS = 72;

    localparam logic [OP_BITS-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_BITS-1:0] OP_ADD = 3'd1;
    localparam logic [OP_BITS-1:0] OP_SUB = 3'd2;
    localparam logic [OP_BITS-1:0] OP_MUL = 3'd3;
    localparam logic [OP_BITS-1:0] OP_DIV = 3'd4;
    localparam logic [OP_BITS-1:0] OP_REDUCE = 3'd5;
    localparam logic [OP_BITS-1:0] OP_COMPARE = 3'd6;

    localparam logic [CMP_BITS-1:0] CMP_EQUAL = 2'd0;
    localparam logic [CMP_BITS-1:0] CMP_LARGER = 2'd1;
    localparam logic [CMP_BITS-1:0] CMP_SMALLER = 2'd2;

    // Command to the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } unit_cmd_t;

endpackage

// ===== design/raa_muldiv.sv =====
// Shared bit-serial unit: unsigned shift-add multiply and restoring divide.
// Depends on raa_pkg and rational_accumulator_alu_macros.svh.
`timescale 1ns / 1ps
`include "rational_accumulator_alu_macros.svh"

module raa_muldiv #(
    parameter int WORD_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  raa_pkg::unit_cmd_t   cmd,
    input  logic [WORD_BITS-1:0] opa,
    input  logic [WORD_BITS-1:0] opb,
    output logic                 done,
    output logic [WORD_BITS-1:0] res_hi,
    output logic [WORD_BITS-1:0] res_lo
);

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 div_reg, div_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] hi_reg, hi_next;
    logic [WORD_BITS-1:0] lo_reg, lo_next;
    logic [WORD_BITS-1:0] mc_reg, mc_next;

    logic [WORD_BITS+1:0] add_x, add_y, add_sum;
    logic [WORD_BITS:0]   shifted;
    logic                 qbit;

    // One adder serves both modes: add of the multiplicand or trial subtract.
    always_comb begin
        shifted = {hi_reg, lo_reg[WORD_BITS-1]};
        if (div_reg) begin
            add_x = {1'b0, shifted};
            add_y = ~{2'b00, mc_reg};
        end else begin
            add_x = {2'b00, hi_reg};
            add_y = lo_reg[0] ? {2'b00, mc_reg} : '0;
        end
        add_sum = add_x + add_y + {{(WORD_BITS+1){1'b0}}, div_reg};
        qbit = !add_sum[WORD_BITS+1];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next = div_reg;
        cnt_next = cnt_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        mc_next = mc_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            div_next = cmd.is_div;
            cnt_next = CNT_BITS'(WORD_BITS);
            hi_next = '0;
            lo_next = opa;
            mc_next = opb;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (div_reg) begin
                hi_next = qbit ? add_sum[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
                lo_next = {lo_reg[WORD_BITS-2:0], qbit};
            end else begin
                hi_next = add_sum[WORD_BITS:1];
                lo_next = {add_sum[0], lo_reg[WORD_BITS-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        div_reg <= div_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        mc_reg <= mc_next;
    end

    assign done = done_reg;
    assign res_hi = hi_reg;
    assign res_lo = lo_reg;

    `RAA_ASSERT_IMPL(a_no_restart, cmd.start, !busy_reg, "unit started while busy")
    `RAA_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "done held longer than one cycle")
    `RAA_ASSERT_IMPL(a_busy_count, busy_reg, cnt_reg != '0, "unit busy with empty count")

endmodule

// ===== design/rational_accumulator_alu.sv =====
// Top level of the rational accumulator ALU: stream ports, sequencer, GCD stepper.
// Depends on raa_pkg, raa_muldiv and rational_accumulator_alu_macros.svh.
`timescale 1ns / 1ps
`include "rational_accumulator_alu_macros.svh"

// Channel   Direction  Fields (lowest bit first)
// s_axis    in         op[2:0], operand_num[34:3], operand_den[66:35], zero fill to 72
// m_axis    out        acc_num[31:0], acc_den[62:32], cmp_code[64:63], is_positive[65],
//                      is_negative[66], is_zero[67], div_zero_error[68], zero fill to 72
//
// One item is in work at a time: s_tready is high only while the block is idle and out
// of reset, and the result sits in the output until m_tready takes it.
// Steps after acceptance: load or compare go straight to the sign compare; multiply or
// divide use the shared bit-serial unit for the numerator and denominator products;
// reduce runs the binary GCD and two divides; add or subtract run the GCD, two divides
// and three products. Every op ends in the compare step, whose two cross products a
// sign difference skips. Reset sets the accumulator to 0/1.

module rational_accumulator_alu #(
    parameter int WORD_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op[2:0], operand_num[34:3], operand_den[66:35]
    input  logic [raa_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // acc_num[31:0], acc_den[62:32], cmp_code[64:63], is_positive[65],
    // is_negative[66], is_zero[67], div_zero_error[68]
    output logic [raa_pkg::M_TDATA_BITS-1:0] m_tdata
);

    localparam int W = WORD_BITS;
    localparam int K_BITS = $clog2(WORD_BITS);
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE_W = W'(1);

    // One-hot sequencer states.
    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_GCD  = 12'b000000000010,
        ST_QA   = 12'b000000000100,
        ST_QB   = 12'b000000001000,
        ST_MT   = 12'b000000010000,
        ST_MN   = 12'b000000100000,
        ST_MD   = 12'b000001000000,
        ST_NORM = 12'b000010000000,
        ST_CMPS = 12'b000100000000,
        ST_CM1  = 12'b001000000000,
        ST_CM2  = 12'b010000000000,
        ST_DONE = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic                         start_reg, start_next;
    logic [raa_pkg::OP_BITS-1:0]  op_reg, op_next;
    logic [W-1:0]                 on_reg, on_next;
    logic [W-1:0]                 od_reg, od_next;
    logic [W-1:0]                 n_reg, n_next;
    logic [W-1:0]                 d_reg, d_next;
    logic [W-1:0]                 g_reg, g_next;
    logic [W-1:0]                 fa_reg, fa_next;
    logic [W-1:0]                 fb_reg, fb_next;
    logic [W-1:0]                 t_reg, t_next;
    logic [W-1:0]                 ga_reg, ga_next;
    logic [W-1:0]                 gb_reg, gb_next;
    logic [K_BITS-1:0]            gk_reg, gk_next;
    logic [2*W-1:0]               ph_reg, ph_next;
    logic [raa_pkg::CMP_BITS-1:0] cmp_reg, cmp_next;
    logic                         err_reg, err_next;

    // Input fields and normalized operand.
    logic [raa_pkg::OP_BITS-1:0]  in_op;
    logic signed [31:0]           in_num;
    logic signed [31:0]           in_den;
    logic [W-1:0]                 on_ext, od_ext, on_neg, od_neg, on_n, od_n;

    // Unit signals.
    raa_pkg::unit_cmd_t           ucmd;
    logic [W-1:0]                 ua, ub, u_hi, u_lo;
    logic                         u_done;

    logic                         is_addsub;
    logic [W-1:0]                 mag_n, mag_on, q_neg, n_neg, d_neg;
    logic [1:0]                   sgn_n, sgn_on;
    logic [2*W-1:0]               prod;
    logic                         accept;

    assign accept = s_tvalid && s_tready;
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DONE);

    assign in_op = s_tdata[2:0];
    assign in_num = s_tdata[34:3];
    assign in_den = s_tdata[66:35];

    // Operand normalization: zero denominator becomes 1, a negative one flips both.
    always_comb begin
        on_ext = W'(in_num);
        od_ext = W'(in_den);
        on_neg = '0 - on_ext;
        od_neg = '0 - od_ext;
        on_n = on_ext;
        od_n = od_ext;
        if (od_ext == '0) begin
            od_n = ONE_W;
        end else if (od_ext[W-1]) begin
            on_n = on_neg;
            od_n = od_neg[W-1] ? MAX_POS : od_neg;
        end
    end

    assign is_addsub = (op_reg == raa_pkg::OP_ADD) || (op_reg == raa_pkg::OP_SUB);
    assign mag_n = n_reg[W-1] ? ('0 - n_reg) : n_reg;
    assign mag_on = on_reg[W-1] ? ('0 - on_reg) : on_reg;
    assign q_neg = '0 - u_lo;
    assign n_neg = '0 - n_reg;
    assign d_neg = '0 - d_reg;
    assign prod = {u_hi, u_lo};
    // Sign rank: 2 positive, 1 zero, 0 negative.
    assign sgn_n = (n_reg == '0) ? 2'd1 : (n_reg[W-1] ? 2'd0 : 2'd2);
    assign sgn_on = (on_reg == '0) ? 2'd1 : (on_reg[W-1] ? 2'd0 : 2'd2);

    // Operand selection for the shared unit, by step and operation.
    always_comb begin
        ua = '0;
        ub = '0;
        ucmd.start = start_reg;
        ucmd.is_div = (state_reg == ST_QA) || (state_reg == ST_QB);
        unique case (state_reg)
            ST_QA: begin
                ua = is_addsub ? od_reg : mag_n;
                ub = g_reg;
            end
            ST_QB: begin
                ua = d_reg;
                ub = g_reg;
            end
            ST_MT: begin
                ua = on_reg;
                ub = fb_reg;
            end
            ST_MN: begin
                ua = n_reg;
                ub = is_addsub ? fa_reg : ((op_reg == raa_pkg::OP_MUL) ? on_reg : od_reg);
            end
            ST_MD: begin
                ua = is_addsub ? fb_reg : d_reg;
                ub = (is_addsub || op_reg == raa_pkg::OP_MUL) ? od_reg : on_reg;
            end
            ST_CM1: begin
                ua = mag_n;
                ub = od_reg;
            end
            ST_CM2: begin
                ua = mag_on;
                ub = d_reg;
            end
            default: begin
                ua = '0;
                ub = '0;
            end
        endcase
    end

    raa_muldiv #(
        .WORD_BITS(W)
    ) u_muldiv (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (ucmd),
        .opa    (ua),
        .opb    (ub),
        .done   (u_done),
        .res_hi (u_hi),
        .res_lo (u_lo)
    );

    always_comb begin
        state_next = state_reg;
        start_next = 1'b0;
        op_next = op_reg;
        on_next = on_reg;
        od_next = od_reg;
        n_next = n_reg;
        d_next = d_reg;
        g_next = g_reg;
        fa_next = fa_reg;
        fb_next = fb_reg;
        t_next = t_reg;
        ga_next = ga_reg;
        gb_next = gb_reg;
        gk_next = gk_reg;
        ph_next = ph_reg;
        cmp_next = cmp_reg;
        err_next = err_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next = in_op;
                    on_next = on_n;
                    od_next = od_n;
                    err_next = (in_op == raa_pkg::OP_LOAD) && (od_ext == '0);
                    gk_next = '0;
                    unique case (in_op)
                        raa_pkg::OP_LOAD: begin
                            n_next = on_n;
                            d_next = od_n;
                            state_next = ST_CMPS;
                        end
                        raa_pkg::OP_ADD, raa_pkg::OP_SUB: begin
                            ga_next = d_reg;
                            gb_next = od_n;
                            state_next = ST_GCD;
                        end
                        raa_pkg::OP_MUL: begin
                            state_next = ST_MN;
                            start_next = 1'b1;
                        end
                        raa_pkg::OP_DIV: begin
                            if (on_n == '0) begin
                                err_next = 1'b1;
                                state_next = ST_CMPS;
                            end else begin
                                state_next = ST_MN;
                                start_next = 1'b1;
                            end
                        end
                        raa_pkg::OP_REDUCE: begin
                            ga_next = mag_n;
                            gb_next = d_reg;
                            state_next = ST_GCD;
                        end
                        default: begin
                            state_next = ST_CMPS;
                        end
                    endcase
                end
            end
            ST_GCD: begin
                // Binary GCD, one step a cycle; common factors of two counted in gk.
                priority if (ga_reg == '0) begin
                    g_next = gb_reg << gk_reg;
                    state_next = ST_QA;
                    start_next = 1'b1;
                end else if (ga_reg == gb_reg) begin
                    g_next = ga_reg << gk_reg;
                    state_next = ST_QA;
                    start_next = 1'b1;
                end else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + 1'b1;
                end else if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else if (ga_reg > gb_reg) begin
                    ga_next = ga_reg - gb_reg;
                end else begin
                    gb_next = gb_reg - ga_reg;
                end
            end
            ST_QA: begin
                if (u_done) begin
                    if (is_addsub) begin
                        fa_next = u_lo;
                    end else begin
                        n_next = n_reg[W-1] ? q_neg : u_lo;
                    end
                    state_next = ST_QB;
                    start_next = 1'b1;
                end
            end
            ST_QB: begin
                if (u_done) begin
                    if (is_addsub) begin
                        fb_next = u_lo;
                        state_next = ST_MT;
                        start_next = 1'b1;
                    end else begin
                        d_next = u_lo;
                        state_next = ST_CMPS;
                    end
                end
            end
            ST_MT: begin
                if (u_done) begin
                    t_next = u_lo;
                    state_next = ST_MN;
                    start_next = 1'b1;
                end
            end
            ST_MN: begin
                if (u_done) begin
                    priority if (op_reg == raa_pkg::OP_ADD) begin
                        n_next = u_lo + t_reg;
                    end else if (op_reg == raa_pkg::OP_SUB) begin
                        n_next = u_lo - t_reg;
                    end else begin
                        n_next = u_lo;
                    end
                    state_next = ST_MD;
                    start_next = 1'b1;
                end
            end
            ST_MD: begin
                if (u_done) begin
                    d_next = u_lo;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // A wrapped denominator is kept positive and nonzero.
                if (d_reg == '0) begin
                    d_next = ONE_W;
                end else if (d_reg[W-1]) begin
                    n_next = n_neg;
                    d_next = d_neg[W-1] ? MAX_POS : d_neg;
                end
                state_next = ST_CMPS;
            end
            ST_CMPS: begin
                if (sgn_n != sgn_on) begin
                    cmp_next = (sgn_n > sgn_on) ? raa_pkg::CMP_LARGER : raa_pkg::CMP_SMALLER;
                    state_next = ST_DONE;
                end else if (sgn_n == 2'd1) begin
                    cmp_next = raa_pkg::CMP_EQUAL;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CM1;
                    start_next = 1'b1;
                end
            end
            ST_CM1: begin
                if (u_done) begin
                    ph_next = prod;
                    state_next = ST_CM2;
                    start_next = 1'b1;
                end
            end
            ST_CM2: begin
                // Cross products of magnitudes; the order flips for negative values.
                if (u_done) begin
                    if (ph_reg == prod) begin
                        cmp_next = raa_pkg::CMP_EQUAL;
                    end else if ((ph_reg > prod) != n_reg[W-1]) begin
                        cmp_next = raa_pkg::CMP_LARGER;
                    end else begin
                        cmp_next = raa_pkg::CMP_SMALLER;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            n_reg <= '0;
            d_reg <= ONE_W;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            n_reg <= n_next;
            d_reg <= d_next;
        end
        op_reg <= op_next;
        on_reg <= on_next;
        od_reg <= od_next;
        g_reg <= g_next;
        fa_reg <= fa_next;
        fb_reg <= fb_next;
        t_reg <= t_next;
        ga_reg <= ga_next;
        gb_reg <= gb_next;
        gk_reg <= gk_next;
        ph_reg <= ph_next;
        cmp_reg <= cmp_next;
        err_reg <= err_next;
    end

    // Result item, built straight from the accumulator and status registers.
    assign m_tdata = {
        3'b000,
        err_reg,
        (n_reg == '0),
        n_reg[W-1],
        ((n_reg != '0) && !n_reg[W-1]),
        cmp_reg,
        raa_pkg::DEN_OUT_BITS'(d_reg),
        raa_pkg::FIELD_BITS'(n_reg)
    };

    `RAA_ASSERT_IMPL(a_one_side, m_tvalid, !s_tready, "input taken while a result waits")
    `RAA_ASSERT_IMPL(a_start_step, start_reg,
        (state_reg != ST_IDLE) && (state_reg != ST_DONE) && (state_reg != ST_GCD),
        "unit started outside a unit step")
    `RAA_ASSERT_IMPL(a_den_positive, m_tvalid, (d_reg != '0) && !d_reg[W-1],
        "accumulator denominator not positive at result")
    `RAA_ASSERT_NEXT(a_gcd_exit, (state_reg == ST_GCD) && (ga_reg == gb_reg),
        state_reg == ST_QA, "GCD stepper did not finish on equal values")

endmodule
